### hw/rtl/bba_pkg.sv
`default_nettype none

package bba_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 64;

    // The block field is 12 bits wide, so no more than this many blocks are addressable
    localparam int FIELD_LIMIT = 4096;

    localparam int BLK_W = 12;          // block number
    localparam int CFG_W = 13;          // total_blocks register
    localparam int SUM_W = 14;          // block arithmetic with one word of headroom
    localparam logic [CFG_W-1:0] TOTAL_RST = CFG_W'(4096);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_FREE     = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_RANGE       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEEK,
        S_FREE_CHK,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic             op;
        logic [BLK_W-1:0] block;
    } t_req;

    typedef struct packed {
        logic [BLK_W-1:0] granted_block;
        logic [1:0]       status;
    } t_resp;

    // controller -> datapath
    typedef struct packed {
        logic    clr_wr;
        logic    load;
        logic    seek_adv;
        logic    rd_en;
        logic    rd_next;
        logic    scan_adv;
        logic    wr_set;
        logic    wr_clr;
        logic    respond;
        logic    grant;
        t_status status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic lim_zero;
        logic blk_range;
        logic seek_done;
        logic hit;
        logic scan_end;
        logic bit_set;
    } t_stat;

endpackage

`default_nettype wire

### hw/rtl/bba_ctrl.sv
`default_nettype none

module bba_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic           i_op,
    input  wire bba_pkg::t_stat i_stat,
    output bba_pkg::t_cmd       o_cmd,
    output logic                o_busy
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = bba_pkg::ST_OK;
        case (r_state)
            bba_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_op == bba_pkg::OP_ALLOC) begin
                        if (i_stat.lim_zero) begin
                            o_cmd.respond = 1'b1;
                            o_cmd.status  = bba_pkg::ST_NO_FREE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = bba_pkg::S_SCAN;
                        end
                    end else if (i_stat.blk_range) begin
                        o_cmd.respond = 1'b1;
                        o_cmd.status  = bba_pkg::ST_RANGE;
                    end else begin
                        n_state = bba_pkg::S_SEEK;
                    end
                end
            end
            bba_pkg::S_SEEK: begin
                if (i_stat.seek_done) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = bba_pkg::S_FREE_CHK;
                end else begin
                    o_cmd.seek_adv = 1'b1;
                end
            end
            bba_pkg::S_FREE_CHK: begin
                o_cmd.respond = 1'b1;
                if (i_stat.bit_set) begin
                    o_cmd.wr_clr = 1'b1;
                    o_cmd.status = bba_pkg::ST_OK;
                end else begin
                    o_cmd.status = bba_pkg::ST_DOUBLE_FREE;
                end
                n_state = bba_pkg::S_IDLE;
            end
            bba_pkg::S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.wr_set  = 1'b1;
                    o_cmd.respond = 1'b1;
                    o_cmd.grant   = 1'b1;
                    o_cmd.status  = bba_pkg::ST_OK;
                    n_state       = bba_pkg::S_IDLE;
                end else if (i_stat.scan_end) begin
                    o_cmd.respond = 1'b1;
                    o_cmd.status  = bba_pkg::ST_NO_FREE;
                    n_state       = bba_pkg::S_IDLE;
                end else begin
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_next  = 1'b1;
                    o_cmd.scan_adv = 1'b1;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != bba_pkg::S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/bba_dpath.sv
`default_nettype none

module bba_dpath #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [bba_pkg::BLK_W-1:0] i_block,
    input  wire logic                      i_cfg_valid,
    input  wire logic [bba_pkg::CFG_W-1:0] i_cfg_data,
    input  wire bba_pkg::t_cmd             i_cmd,
    output bba_pkg::t_stat                 o_stat,
    output logic                           o_res_valid,
    output bba_pkg::t_resp                 o_resp
);

    localparam int EFF_BLOCKS = (MAX_BLOCKS < bba_pkg::FIELD_LIMIT) ?
                                MAX_BLOCKS : bba_pkg::FIELD_LIMIT;
    localparam int WORDS = (EFF_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OW    = $clog2(WORD_BITS);
    localparam int SW    = bba_pkg::SUM_W;

    logic [WORD_BITS-1:0] mem [WORDS];

    logic [bba_pkg::CFG_W-1:0] r_total;
    logic [bba_pkg::BLK_W-1:0] r_block;
    logic [AW-1:0]             r_word;
    logic [SW-1:0]             r_base;
    logic [AW-1:0]             r_clr_addr;
    logic [WORD_BITS-1:0]      r_rd_data;
    logic                      r_res_valid;
    bba_pkg::t_resp            r_resp;

    logic [bba_pkg::CFG_W-1:0] lim;
    logic [SW-1:0]             lim_w;
    logic [SW-1:0]             base_nxt;
    logic [SW-1:0]             rem;
    logic [OW-1:0]             offset;
    logic [WORD_BITS-1:0]      free_bits;
    logic [OW-1:0]             idx;
    logic                      hit;
    logic [AW-1:0]             rd_addr;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [WORD_BITS-1:0]      wr_data;
    logic [bba_pkg::BLK_W-1:0] granted;

    // Effective limit: register saturated at the block count the memory holds
    assign lim = (r_total > bba_pkg::CFG_W'(EFF_BLOCKS)) ?
                 bba_pkg::CFG_W'(EFF_BLOCKS) : r_total;
    assign lim_w    = SW'(lim);
    assign base_nxt = r_base + SW'(WORD_BITS);
    assign rem      = lim_w - r_base;
    assign offset   = OW'(SW'(r_block) - r_base);

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            free_bits[i] = ~r_rd_data[i] & (SW'(i) < rem);
        end
    end

    // lowest free bit in the word under test
    always_comb begin
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                idx = OW'(i);
            end
        end
    end

    assign hit     = |free_bits;
    assign granted = bba_pkg::BLK_W'(r_base + SW'(idx));

    assign o_stat.clr_last  = (r_clr_addr == AW'(WORDS - 1));
    assign o_stat.lim_zero  = (lim == '0);
    assign o_stat.blk_range = (SW'(i_block) >= lim_w);
    assign o_stat.seek_done = (SW'(r_block) < base_nxt);
    assign o_stat.hit       = hit;
    assign o_stat.scan_end  = (base_nxt >= lim_w);
    assign o_stat.bit_set   = r_rd_data[offset];

    assign rd_addr = i_cmd.rd_next ? (r_word + AW'(1)) : r_word;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_word;
        wr_data = r_rd_data;
        if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (i_cmd.wr_set) begin
            wr_en   = 1'b1;
            wr_data = r_rd_data | (WORD_BITS'(1) << idx);
        end else if (i_cmd.wr_clr) begin
            wr_en   = 1'b1;
            wr_data = r_rd_data & ~(WORD_BITS'(1) << offset);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_block <= i_block;
        end
        if (i_cmd.respond) begin
            r_resp.status        <= i_cmd.status;
            r_resp.granted_block <= i_cmd.grant ? granted : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= bba_pkg::TOTAL_RST;
            r_word      <= '0;
            r_base      <= '0;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_total <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            // word pointer returns to the start once an item is answered
            if (i_cmd.respond) begin
                r_word <= '0;
                r_base <= '0;
            end else if (i_cmd.seek_adv || i_cmd.scan_adv) begin
                r_word <= r_word + AW'(1);
                r_base <= base_nxt;
            end
            r_res_valid <= i_cmd.respond;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_resp      = r_resp;

endmodule

`default_nettype wire

### hw/rtl/block_bitmap_allocator_core.sv
// First-fit block allocator over a one-bit-per-block usage map held in a single-port-style
// memory of ceil(min(MAX_BLOCKS,4096)/WORD_BITS) words (64 at the defaults). After reset
// the block runs a clearing pass, one word per cycle, with busy high; config writes are
// still taken then. An item is taken when start is high and busy is low. Allocate: the
// accept cycle reads the first map word, then the scan tests one word a cycle, from the
// first word to the word holding the lowest free block (or to the last word below
// total_blocks). Free: the block steps word by word to the word holding the block, reads
// it, then checks and clears the bit. An out-of-range free, or an allocate with a zero
// block count, is answered from the accept cycle alone. o_res_valid marks the result on
// o_resp, high for exactly one cycle, in the cycle after the item's last busy cycle (the
// accept cycle for an item answered at once); there is no back-pressure, so the receiver
// must take it then. A new item can be accepted in the same cycle as that strobe.
// granted_block is zero unless status is ok for an allocate.
`default_nettype none

module block_bitmap_allocator_core #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // request item
    input  wire logic                      start,
    output logic                           busy,
    input  wire bba_pkg::t_req             i_req,
    // result item, one-cycle strobe
    output logic                           o_res_valid,
    output bba_pkg::t_resp                 o_resp,
    // total_blocks write
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [bba_pkg::CFG_W-1:0] i_cfg_data
);

    bba_pkg::t_cmd  cmd;
    bba_pkg::t_stat stat;

    // Register writes are taken at any time
    assign o_cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_req.op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bba_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_block     (i_req.block),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .o_resp      (o_resp)
    );

endmodule

`default_nettype wire

### hw/rtl/bba_checker.sv
`default_nettype none

module bba_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           o_res_valid,
    input wire bba_pkg::t_resp o_resp
);

    // reset always starts the clearing pass
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low after reset");

    // an item either keeps the block busy or is answered at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_res_valid))
        else $error("accepted item neither busy nor answered");

    // results only appear once the block has gone idle
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result strobe while busy");

    // a block number is only handed out on success
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_resp.status != bba_pkg::ST_OK)) |-> (o_resp.granted_block == '0))
        else $error("nonzero block on failed result");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_resp      (o_resp)
);

`default_nettype wire
